[hdl/spr_pkg.sv]
package spr_pkg;

   // field and register widths
   localparam int BYTE_W    = 8;
   localparam int CFG_W     = 64;
   localparam int LEN_W     = 4;
   localparam int CSR_IDX_W = 4;

   // replacement holds at most eight characters
   localparam int REPL_MAX  = 8;
   localparam int RIDX_W    = 3;

   // default window depth
   localparam int MAX_PATTERN_DEFAULT = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_BYTES  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = CSR_IDX_W'(3);

   // register reset values
   localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET     = LEN_W'(1);
   localparam logic [LEN_W-1:0] REPLACEMENT_LENGTH_RESET = LEN_W'(0);

endpackage

[hdl/spr_if.sv]
// input text byte channel
interface spr_req_if
   import spr_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// result byte channel
interface spr_rsp_if
   import spr_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              has_byte;
   logic              out_last;

   modport source (output valid, output out_byte, output has_byte, output out_last,
                   input ready);
   modport sink   (input valid, input out_byte, input has_byte, input out_last,
                   output ready);
endinterface

// register write channel
interface spr_csr_if
   import spr_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/stream_pattern_replace.sv]
// output: each result goes through the single result register to the outputs; the first
//    result of a transaction follows its accept, or, when nothing is popped first and it starts a
//    replacement or the final flush, comes from that state
// throughput: one byte per cycle when the result register is free; a match holds input
//    while its replacement is sent, the last byte while the window is flushed
// reset: synchronous, active high; clears the window, the handshake state and sets the
//    registers to pattern length 1, replacement length 0, all characters zero
module stream_pattern_replace
   import spr_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   spr_req_if.sink     req_chan,
   spr_rsp_if.source   rsp_chan,
   spr_csr_if.sink     csr_chan
);

   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PATTERN);

   typedef enum logic [2:0] {
      ST_PRE   = 3'b001,
      ST_REPL  = 3'b010,
      ST_FLUSH = 3'b100
   } phase_type;

   typedef logic [BYTE_W-1:0] byte_type;

   // configuration registers
   logic [CFG_W-1:0] pat_ff;
   logic [LEN_W-1:0] plen_ff;
   logic [CFG_W-1:0] repl_ff;
   logic [LEN_W-1:0] rlen_ff;

   // input register
   logic     pend_valid_ff;
   byte_type pend_byte_ff;
   logic     pend_last_ff;

   // window state
   byte_type          win_ff [MAX_PATTERN];
   byte_type          win_in [MAX_PATTERN];
   logic [CW-1:0]     cnt_ff, cnt_in;
   phase_type         state_ff, state_in;
   logic [RIDX_W-1:0] idx_ff, idx_in;

   // result register
   logic     rsp_valid_ff;
   byte_type rsp_byte_ff;
   logic     rsp_has_ff;
   logic     rsp_last_ff;

   // step signals
   logic          [CW-1:0] plen_eff;
   logic       [LEN_W-1:0] rlen_eff;
   byte_type               win_shift [MAX_PATTERN];
   byte_type               w_src     [MAX_PATTERN];
   byte_type               wa        [MAX_PATTERN];
   logic          [CW-1:0] c_src, ca;
   logic                   pop, mism, match, rlast;
   logic                   emit, e_has, e_last, done;
   byte_type               e_byte;
   logic                   out_free, step_go, req_fire;

   // effective lengths
   always_comb begin
      if (plen_ff == '0) begin
         plen_eff = CW'(1);
      end else if (plen_ff > LEN_W'(MAX_PATTERN)) begin
         plen_eff = MAX_CNT;
      end else begin
         plen_eff = plen_ff[CW-1:0];
      end
      rlen_eff = (rlen_ff > LEN_W'(REPL_MAX)) ? LEN_W'(REPL_MAX) : rlen_ff;
   end

   // window with the oldest byte removed
   always_comb begin
      for (int k = 0; k < MAX_PATTERN - 1; k++) begin
         win_shift[k] = win_ff[k + 1];
      end
      win_shift[MAX_PATTERN - 1] = '0;
   end

   // window after pending pops and after the append
   always_comb begin
      pop   = (cnt_ff >= plen_eff) && (cnt_ff != '0);
      c_src = pop ? (cnt_ff - CW'(1)) : cnt_ff;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         w_src[k] = pop ? win_shift[k] : win_ff[k];
         wa[k]    = (CW'(k) == c_src) ? pend_byte_ff : w_src[k];
      end
      ca   = (c_src < MAX_CNT) ? (c_src + CW'(1)) : c_src;
      mism = 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if ((CW'(k) < plen_eff) && (wa[k] != pat_ff[BYTE_W*k +: BYTE_W])) begin
            mism = 1'b1;
         end
      end
      match = (ca == plen_eff) && !mism;
      rlast = ((LEN_W'(idx_ff) + LEN_W'(1)) == rlen_eff);
   end

   // step sequencer
   always_comb begin
      win_in   = win_ff;
      cnt_in   = cnt_ff;
      state_in = state_ff;
      idx_in   = idx_ff;
      emit     = 1'b0;
      e_byte   = win_ff[0];
      e_has    = 1'b1;
      e_last   = 1'b0;
      done     = 1'b0;
      case (state_ff)
         ST_PRE: begin
            if (pop && (c_src >= plen_eff)) begin
               // window longer than the pattern, keep draining
               emit   = 1'b1;
               win_in = win_shift;
               cnt_in = c_src;
            end else begin
               emit = pop;
               done = 1'b1;
               if (match) begin
                  for (int k = 0; k < MAX_PATTERN; k++) begin
                     win_in[k] = '0;
                  end
                  cnt_in = '0;
                  if (rlen_eff != '0) begin
                     state_in = ST_REPL;
                     idx_in   = '0;
                     done     = 1'b0;
                  end else if (pend_last_ff) begin
                     if (pop) begin
                        e_last = 1'b1;
                     end else begin
                        // nothing to send, end marker only
                        emit   = 1'b1;
                        e_byte = '0;
                        e_has  = 1'b0;
                        e_last = 1'b1;
                     end
                  end
               end else begin
                  win_in = wa;
                  cnt_in = ca;
                  if (pend_last_ff) begin
                     state_in = ST_FLUSH;
                     done     = 1'b0;
                  end
               end
            end
         end
         ST_REPL: begin
            emit   = 1'b1;
            e_byte = repl_ff[BYTE_W*idx_ff +: BYTE_W];
            e_last = pend_last_ff && rlast;
            idx_in = idx_ff + RIDX_W'(1);
            if (rlast) begin
               state_in = ST_PRE;
               done     = 1'b1;
            end
         end
         ST_FLUSH: begin
            emit   = 1'b1;
            e_last = (cnt_ff == CW'(1));
            win_in = win_shift;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_PRE;
               done     = 1'b1;
            end
         end
         default: begin
            state_in = ST_PRE;
         end
      endcase
   end

   // handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step_go        = pend_valid_ff && (out_free || !emit);
   assign req_chan.ready = !pend_valid_ff || (step_go && done);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.has_byte = rsp_has_ff;
   assign rsp_chan.out_last = rsp_last_ff;

   // control and window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= ST_PRE;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            win_ff[k] <= '0;
         end
         pat_ff  <= '0;
         plen_ff <= PATTERN_LENGTH_RESET;
         repl_ff <= '0;
         rlen_ff <= REPLACEMENT_LENGTH_RESET;
      end else begin
         // input register
         if (req_fire) begin
            pend_valid_ff <= 1'b1;
         end else if (step_go && done) begin
            pend_valid_ff <= 1'b0;
         end
         // window update
         if (step_go) begin
            state_ff <= state_in;
            cnt_ff   <= cnt_in;
            idx_ff   <= idx_in;
            win_ff   <= win_in;
         end
         // result register
         if (step_go && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // register writes
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_PATTERN_BYTES:      pat_ff  <= csr_chan.data;
               CSR_PATTERN_LENGTH:     plen_ff <= csr_chan.data[LEN_W-1:0];
               CSR_REPLACEMENT_BYTES:  repl_ff <= csr_chan.data;
               CSR_REPLACEMENT_LENGTH: rlen_ff <= csr_chan.data[LEN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_byte_ff <= req_chan.in_byte;
         pend_last_ff <= req_chan.in_last;
      end
      if (step_go && emit) begin
         rsp_byte_ff <= e_byte;
         rsp_has_ff  <= e_has;
         rsp_last_ff <= e_last;
      end
   end

`ifndef SYNTHESIS
   // flush only runs with bytes left in the window
   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (cnt_ff != '0))
      else $error("flush with empty window");

   // a match always empties the window before the replacement burst
   a_repl_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPL) |-> (cnt_ff == '0))
      else $error("replacement with bytes in window");

   // window never exceeds its depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("window count out of range");

   // a drained input register always takes the next transaction
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !pend_valid_ff |-> req_chan.ready)
      else $error("input stalled while empty");
`endif

endmodule
